// File: rtl/min_cover_window_finder_macros.svh
// Assertion macros for the minimum cover window finder.
// Included by the RTL file that carries concurrent checks; no dependencies.
`ifndef MIN_COVER_WINDOW_FINDER_MACROS_SVH
`define MIN_COVER_WINDOW_FINDER_MACROS_SVH
`ifndef SYNTHESIS
`define MCW_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define MCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define MCW_ASSERT(label, clk, rst_n, ante, cons)
`define MCW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/mcw_pkg.sv
// Shared constants, types and codes of the minimum cover window finder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mcw_pkg;
    localparam int MAX_TEXT    = 4096;
    localparam int MAX_PATTERN = 256;
    localparam int SYM_W       = 8;
    localparam int SYM_N       = 1 << SYM_W;
    localparam int TEXT_AW     = $clog2(MAX_TEXT);
    localparam int IDX_W       = $clog2(MAX_TEXT + 1);
    localparam int NEED_W      = $clog2(MAX_PATTERN + 1);
    localparam int HAVE_W      = IDX_W;
    localparam int START_W     = 12;
    localparam int LEN_W       = 13;

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    typedef logic [SYM_W-1:0] t_sym;
    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [NEED_W-1:0] need;
        logic [HAVE_W-1:0] have;
    } t_cnt;

    typedef struct packed {
        logic clr;
        logic rd_en;
        t_sym rd_addr;
        logic wr_en;
        t_sym wr_addr;
        t_cnt wr_data;
    } t_cnt_req;
endpackage
`default_nettype wire

// File: rtl/mcw_if.sv
// Input and result channels of the minimum cover window finder.
// Depends on mcw_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface mcw_in_if;
    import mcw_pkg::*;
    logic       valid;
    logic       ready;
    logic       cmd;
    t_sym       symbol;
    logic       last;
    modport source(output valid, cmd, symbol, last, input ready);
    modport sink(input valid, cmd, symbol, last, output ready);
endinterface

interface mcw_out_if;
    import mcw_pkg::*;
    logic               valid;
    logic               ready;
    logic               found;
    logic [START_W-1:0] start_res;
    logic [LEN_W-1:0]   length;
    logic               overflow;
    modport source(output valid, found, start_res, length, overflow, input ready);
    modport sink(input valid, found, start_res, length, overflow, output ready);
endinterface
`default_nettype wire

// File: rtl/mcw_cnt_store.sv
// Needed/held count table per byte value: synchronous memory with a read and
// a write port; a job clear resets just its valid bits. Depends on mcw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcw_cnt_store (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  mcw_pkg::t_cnt_req  i_req,
    output mcw_pkg::t_cnt      o_rd_data
);
    import mcw_pkg::*;

    t_cnt             r_mem [SYM_N];
    logic [SYM_N-1:0] r_vld;
    t_cnt             r_rd_q;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_q   <= r_mem[i_req.rd_addr];
            r_rd_vld <= r_vld[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_q : '0;
endmodule
`default_nettype wire

// File: rtl/min_cover_window_finder.sv
// Minimum cover window finder: top level with sequencer and text buffer.
// Depends on mcw_pkg, mcw_if, mcw_cnt_store and the assertion macros.
//
// Load pattern bytes (cmd 0), then stream text bytes (cmd 1); the word with
// last set on a text byte yields one result word (found, start, length,
// overflow) and clears the job. A pattern byte's count is read and written
// back with need raised. A text byte goes into the buffer and its held count
// is raised; bytes held in surplus are then dropped from the window's left
// (buffer read, count read, count write), the window is checked against the
// best, and on the last byte the result is loaded once the output register
// is free. A text byte beyond the buffer only sets overflow. Each byte is
// dropped at most once. The steps follow the read-modify-write loop on the
// count memory and the buffer read feeding it. One result word may wait in
// the output register while new words are taken, which happens only in idle.
`timescale 1ns / 1ps
`default_nettype none
`include "min_cover_window_finder_macros.svh"
module min_cover_window_finder (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mcw_in_if.sink    i_in,
    mcw_out_if.source o_out
);
    import mcw_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_PAT_WR  = 8'b0000_0010,
        S_TXT_WR  = 8'b0000_0100,
        S_LFT_RD  = 8'b0000_1000,
        S_LFT_CNT = 8'b0001_0000,
        S_LFT_CHK = 8'b0010_0000,
        S_FIN     = 8'b0100_0000,
        S_OUT     = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    t_sym                r_sym, n_sym;
    logic                r_last, n_last;
    t_idx                r_left, n_left;
    t_idx                r_right, n_right;
    logic [NEED_W-1:0]   r_match, n_match;
    logic [NEED_W-1:0]   r_plen, n_plen;
    logic [TEXT_AW-1:0]  r_best_start, n_best_start;
    t_idx                r_best_len, n_best_len;
    logic                r_ovf, n_ovf;
    logic                r_o_valid, n_o_valid;
    logic                r_o_found, n_o_found;
    logic [START_W-1:0]  r_o_start, n_o_start;
    logic [LEN_W-1:0]    r_o_len, n_o_len;
    logic                r_o_ovf, n_o_ovf;

    t_sym                r_text [MAX_TEXT];
    t_sym                r_text_q;
    logic                tb_we;
    logic                tb_re;

    t_cnt_req            cs_req;
    t_cnt                cs_q;
    logic                accept;
    logic [HAVE_W-1:0]   have_inc;
    t_idx                win_len;

    mcw_cnt_store u_cnt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (cs_req),
        .o_rd_data (cs_q)
    );

    always_ff @(posedge i_clk) begin
        if (tb_we) begin
            r_text[r_right[TEXT_AW-1:0]] <= i_in.symbol;
        end
        if (tb_re) begin
            r_text_q <= r_text[r_left[TEXT_AW-1:0]];
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign have_inc   = cs_q.have + HAVE_W'(1);
    assign win_len    = r_right - r_left + IDX_W'(1);

    always_comb begin
        n_state      = r_state;
        n_sym        = r_sym;
        n_last       = r_last;
        n_left       = r_left;
        n_right      = r_right;
        n_match      = r_match;
        n_plen       = r_plen;
        n_best_start = r_best_start;
        n_best_len   = r_best_len;
        n_ovf        = r_ovf;
        n_o_valid    = r_o_valid;
        n_o_found    = r_o_found;
        n_o_start    = r_o_start;
        n_o_len      = r_o_len;
        n_o_ovf      = r_o_ovf;
        tb_we        = 1'b0;
        tb_re        = 1'b0;
        cs_req       = '0;

        if (r_o_valid && o_out.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_sym  = i_in.symbol;
                    n_last = i_in.last;
                    cs_req.rd_addr = i_in.symbol;
                    if (i_in.cmd == CMD_PATTERN) begin
                        if (r_plen < NEED_W'(MAX_PATTERN)) begin
                            cs_req.rd_en = 1'b1;
                            n_state      = S_PAT_WR;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (r_right >= IDX_W'(MAX_TEXT)) begin
                        n_ovf = 1'b1;
                        if (i_in.last) begin
                            n_state = S_OUT;
                        end
                    end else begin
                        tb_we        = 1'b1;
                        cs_req.rd_en = 1'b1;
                        n_state      = S_TXT_WR;
                    end
                end
            end
            S_PAT_WR: begin
                cs_req.wr_en        = 1'b1;
                cs_req.wr_addr      = r_sym;
                cs_req.wr_data.need = cs_q.need + NEED_W'(1);
                cs_req.wr_data.have = cs_q.have;
                n_plen              = r_plen + NEED_W'(1);
                n_state             = S_IDLE;
            end
            S_TXT_WR: begin
                cs_req.wr_en        = 1'b1;
                cs_req.wr_addr      = r_sym;
                cs_req.wr_data.need = cs_q.need;
                cs_req.wr_data.have = have_inc;
                if (have_inc <= HAVE_W'(cs_q.need)) begin
                    n_match = r_match + NEED_W'(1);
                end
                n_state = S_LFT_RD;
            end
            S_LFT_RD: begin
                if (r_left <= r_right) begin
                    tb_re   = 1'b1;
                    n_state = S_LFT_CNT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_LFT_CNT: begin
                cs_req.rd_en   = 1'b1;
                cs_req.rd_addr = r_text_q;
                n_state        = S_LFT_CHK;
            end
            S_LFT_CHK: begin
                if (cs_q.have <= HAVE_W'(cs_q.need)) begin
                    n_state = S_FIN;
                end else begin
                    // drop surplus byte from the left edge
                    cs_req.wr_en        = 1'b1;
                    cs_req.wr_addr      = r_text_q;
                    cs_req.wr_data.need = cs_q.need;
                    cs_req.wr_data.have = cs_q.have - HAVE_W'(1);
                    n_left              = r_left + IDX_W'(1);
                    n_state             = S_LFT_RD;
                end
            end
            S_FIN: begin
                if (r_plen != '0 && r_match == r_plen && r_left <= r_right) begin
                    if (r_best_len == '0 || r_best_len > win_len) begin
                        n_best_len   = win_len;
                        n_best_start = r_left[TEXT_AW-1:0];
                    end
                end
                n_right = r_right + IDX_W'(1);
                n_state = r_last ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid    = 1'b1;
                    n_o_found    = (r_best_len != '0);
                    n_o_start    = START_W'(r_best_start);
                    n_o_len      = LEN_W'(r_best_len);
                    n_o_ovf      = r_ovf;
                    cs_req.clr   = 1'b1;
                    n_left       = '0;
                    n_right      = '0;
                    n_match      = '0;
                    n_plen       = '0;
                    n_best_start = '0;
                    n_best_len   = '0;
                    n_ovf        = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last       <= 1'b0;
            r_left       <= '0;
            r_right      <= '0;
            r_match      <= '0;
            r_plen       <= '0;
            r_best_start <= '0;
            r_best_len   <= '0;
            r_ovf        <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_last       <= n_last;
            r_left       <= n_left;
            r_right      <= n_right;
            r_match      <= n_match;
            r_plen       <= n_plen;
            r_best_start <= n_best_start;
            r_best_len   <= n_best_len;
            r_ovf        <= n_ovf;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym     <= n_sym;
        r_o_found <= n_o_found;
        r_o_start <= n_o_start;
        r_o_len   <= n_o_len;
        r_o_ovf   <= n_o_ovf;
    end

    assign o_out.valid     = r_o_valid;
    assign o_out.found     = r_o_found;
    assign o_out.start_res = r_o_start;
    assign o_out.length    = r_o_len;
    assign o_out.overflow  = r_o_ovf;

    `MCW_ASSERT(a_left_le_right, i_clk, i_rst_n, r_state == S_IDLE, r_left <= r_right)
    `MCW_ASSERT(a_match_le_plen, i_clk, i_rst_n, 1'b1, r_match <= r_plen)
    `MCW_ASSERT(a_best_in_text, i_clk, i_rst_n, r_state == S_IDLE, r_best_len <= r_right)
    `MCW_ASSERT_NEXT(a_clear_on_result, i_clk, i_rst_n,
        r_state == S_OUT && (!r_o_valid || o_out.ready),
        r_right == '0 && r_plen == '0 && r_o_valid)
endmodule
`default_nettype wire
